>>> hw/rtl/selt_pkg.sv
package selt_pkg;

  localparam int unsigned SLOT_W = 5;
  localparam int unsigned KEY_W  = 32;

  typedef enum logic [1:0] {
    REQ_SHARED  = 2'd0,
    REQ_EXCL    = 2'd1,
    REQ_UNLOCK  = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_CONF_X = 2'd1,
    STAT_CONF_S = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FIND,
    ST_RESP
  } state_t;

endpackage

>>> hw/rtl/selt_if.sv
interface selt_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic [selt_pkg::SLOT_W-1:0]    tx_slot;
  logic [selt_pkg::KEY_W-1:0]     resource_key;

  modport source (output valid, output req_type, output tx_slot, output resource_key,
                  input ready);
  modport sink (input valid, input req_type, input tx_slot, input resource_key,
                output ready);
endinterface

interface selt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [selt_pkg::SLOT_W-1:0]    holder_tx;

  modport source (output valid, output status, output holder_tx, input ready);
  modport sink (input valid, input status, input holder_tx, output ready);
endinterface

>>> hw/rtl/shared_exclusive_lock_table.sv
// Shared/exclusive lock table. Each request gives exactly one response. After reset the
// block first runs a clearing pass over the table memory and accepts no request
// meanwhile. A lock or unlock request walks the whole table once through the single read
// port of the table memory, one entry per cycle; an exclusive request that meets other
// shared holders then searches the holder bitmap one bit per cycle. A release-all request
// reads every entry and rewrites every valid one in one pass. A request from slot 0 or
// from a slot not below TX_SLOTS answers done. The block works on one request at a time;
// the response register lets the next request start while the previous response is still
// waiting.
module shared_exclusive_lock_table #(
  parameter int ENTRIES  = 64,
  parameter int TX_SLOTS = 32,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  selt_req_if.sink    in_req,
  selt_rsp_if.source  out_rsp
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int MW = (TX_SLOTS < 32) ? TX_SLOTS : 32;
  localparam int SW = selt_pkg::SLOT_W;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef struct packed {
    logic          valid;
    logic [KW-1:0] key;
    logic [SW-1:0] excl;
    logic [MW-1:0] smap;
  } entry_t;

  function automatic entry_t drop_holds(entry_t e, logic [SW-1:0] s);
    entry_t r;
    r = e;
    if (r.excl == s) begin
      r.excl = '0;
    end
    r.smap = r.smap & ~(MW'(1) << s);
    if (r.excl == '0 && r.smap == '0) begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  entry_t entry_mem_r [ENTRIES];
  entry_t rdata_r;

  selt_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          issue_r, issue_nxt;
  logic          chk_r, chk_nxt;
  logic [AW-1:0] chk_idx_r, chk_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  entry_t        hit_ent_r, hit_ent_nxt;
  logic          free_r, free_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic [1:0]    req_r, req_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [MW-1:0] bits_r, bits_nxt;
  logic [SW-1:0] bit_idx_r, bit_idx_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [SW-1:0] res_holder_r, res_holder_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [SW-1:0] out_holder_r, out_holder_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_idx;
  entry_t        wr_data;
  logic [MW-1:0] own;
  logic [MW-1:0] others;
  entry_t        upd;

  assign in_req.ready      = (state_r == selt_pkg::ST_IDLE);
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.holder_tx = out_holder_r;

  assign own    = MW'(1) << slot_r;
  assign others = hit_ent_r.smap & ~own;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_idx] <= wr_data;
    end
    rdata_r <= entry_mem_r[cnt_r];
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    issue_nxt      = issue_r;
    chk_nxt        = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_ent_nxt    = hit_ent_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    req_nxt        = req_r;
    slot_nxt       = slot_r;
    key_nxt        = key_r;
    bits_nxt       = bits_r;
    bit_idx_nxt    = bit_idx_r;
    res_status_nxt = res_status_r;
    res_holder_nxt = res_holder_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_holder_nxt = out_holder_r;
    wr_en          = 1'b0;
    wr_idx         = cnt_r;
    wr_data        = '0;
    upd            = hit_ent_r;

    case (state_r)
      selt_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_idx  = cnt_r;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = selt_pkg::ST_IDLE;
        end
      end

      selt_pkg::ST_IDLE: begin
        if (in_req.valid) begin
          req_nxt        = in_req.req_type;
          slot_nxt       = in_req.tx_slot;
          key_nxt        = in_req.resource_key[KW-1:0];
          res_status_nxt = selt_pkg::STAT_DONE;
          res_holder_nxt = '0;
          if (in_req.tx_slot != '0 && 32'(in_req.tx_slot) < TX_SLOTS) begin
            cnt_nxt   = '0;
            issue_nxt = 1'b1;
            hit_nxt   = 1'b0;
            free_nxt  = 1'b0;
            state_nxt = selt_pkg::ST_SCAN;
          end else begin
            state_nxt = selt_pkg::ST_RESP;
          end
        end
      end

      selt_pkg::ST_SCAN: begin
        // Reads are issued one entry ahead of the entry being checked.
        chk_nxt     = issue_r;
        chk_idx_nxt = cnt_r;
        if (issue_r) begin
          cnt_nxt = cnt_r + AW'(1);
          if (cnt_r == LAST) begin
            issue_nxt = 1'b0;
          end
        end
        if (chk_r) begin
          if (req_r == selt_pkg::REQ_RELEASE) begin
            if (rdata_r.valid) begin
              wr_en   = 1'b1;
              wr_idx  = chk_idx_r;
              wr_data = drop_holds(rdata_r, slot_r);
            end
          end else begin
            if (rdata_r.valid && rdata_r.key == key_r && !hit_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = chk_idx_r;
              hit_ent_nxt = rdata_r;
            end
            if (!rdata_r.valid && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = chk_idx_r;
            end
          end
          if (chk_idx_r == LAST) begin
            cnt_nxt   = '0;
            state_nxt = (req_r == selt_pkg::REQ_RELEASE) ? selt_pkg::ST_RESP
                                                         : selt_pkg::ST_DECIDE;
          end
        end
      end

      selt_pkg::ST_DECIDE: begin
        state_nxt = selt_pkg::ST_RESP;
        if (req_r == selt_pkg::REQ_UNLOCK) begin
          if (hit_r) begin
            wr_en   = 1'b1;
            wr_idx  = hit_idx_r;
            wr_data = drop_holds(hit_ent_r, slot_r);
          end
        end else if (hit_r && hit_ent_r.excl != '0 && hit_ent_r.excl != slot_r) begin
          res_status_nxt = selt_pkg::STAT_CONF_X;
          res_holder_nxt = hit_ent_r.excl;
        end else if (hit_r && req_r == selt_pkg::REQ_EXCL && others != '0) begin
          bits_nxt    = others;
          bit_idx_nxt = '0;
          state_nxt   = selt_pkg::ST_FIND;
        end else if (hit_r || free_r) begin
          if (!hit_r) begin
            upd.valid = 1'b1;
            upd.key   = key_r;
            upd.excl  = '0;
            upd.smap  = '0;
          end
          if (req_r == selt_pkg::REQ_SHARED) begin
            upd.smap = upd.smap | own;
          end else begin
            upd.smap = upd.smap & ~own;
            upd.excl = slot_r;
          end
          wr_en   = 1'b1;
          wr_idx  = hit_r ? hit_idx_r : free_idx_r;
          wr_data = upd;
        end else begin
          res_status_nxt = selt_pkg::STAT_FULL;
        end
      end

      selt_pkg::ST_FIND: begin
        // Walk the other shared holders from the lowest slot upward.
        if (bits_r[0]) begin
          res_status_nxt = selt_pkg::STAT_CONF_S;
          res_holder_nxt = bit_idx_r;
          state_nxt      = selt_pkg::ST_RESP;
        end else begin
          bits_nxt    = bits_r >> 1;
          bit_idx_nxt = bit_idx_r + SW'(1);
        end
      end

      selt_pkg::ST_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_holder_nxt = res_holder_r;
          state_nxt      = selt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = selt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= selt_pkg::ST_CLEAR;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      chk_r       <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      issue_r     <= issue_nxt;
      chk_r       <= chk_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_ent_r    <= hit_ent_nxt;
    free_idx_r   <= free_idx_nxt;
    req_r        <= req_nxt;
    slot_r       <= slot_nxt;
    key_r        <= key_nxt;
    bits_r       <= bits_nxt;
    bit_idx_r    <= bit_idx_nxt;
    res_status_r <= res_status_nxt;
    res_holder_r <= res_holder_nxt;
    out_status_r <= out_status_nxt;
    out_holder_r <= out_holder_nxt;
  end

endmodule

>>> bench/shared_exclusive_lock_table_tb.sv
`timescale 1ns / 100ps

module shared_exclusive_lock_table_tb;

  localparam int ENTRIES     = 64;
  localparam int TX_SLOTS    = 32;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int TAIL_CYCLES = 150;

  localparam logic [31:0] KEY_A = 32'hA5A5_0001;
  localparam logic [31:0] KEY_B = 32'h5A5A_0002;

  typedef struct packed {
    selt_pkg::status_t status;
    logic [4:0]        holder;
  } lock_answer_t;

  logic clk = 1'b0;
  logic rst_n;

  selt_req_if in_req();
  selt_rsp_if out_rsp();

  shared_exclusive_lock_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  // Our own copy of the lock table.
  logic        held_valid  [ENTRIES];
  logic [31:0] held_key    [ENTRIES];
  logic [4:0]  held_excl   [ENTRIES];
  logic [31:0] held_shared [ENTRIES];

  lock_answer_t pending_answers[$];
  int           mismatches = 0;
  longint       cycle_count = 0;
  bit           steady = 1'b0;
  bit           hold_req = 1'b0;
  int           hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("shared_exclusive_lock_table_tb NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic int lookup_key(logic [31:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (held_valid[i] && held_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int first_free_entry();
    for (int i = 0; i < ENTRIES; i++)
      if (!held_valid[i]) return i;
    return -1;
  endfunction

  function automatic void drop_slot_holds(int e, logic [4:0] slot);
    if (held_excl[e] == slot) held_excl[e] = '0;
    held_shared[e][slot] = 1'b0;
    if (held_excl[e] == '0 && held_shared[e] == '0) held_valid[e] = 1'b0;
  endfunction

  function automatic lock_answer_t predict_lock_answer(selt_pkg::req_t kind,
                                                       logic [4:0] slot,
                                                       logic [31:0] key);
    lock_answer_t ans;
    int           e;
    logic [31:0]  own;
    logic [31:0]  others;
    ans.status = selt_pkg::STAT_DONE;
    ans.holder = '0;
    if (slot == '0 || int'(slot) >= TX_SLOTS) return ans;
    own = 32'd1 << slot;
    case (kind)
      selt_pkg::REQ_SHARED, selt_pkg::REQ_EXCL: begin
        e = lookup_key(key);
        if (e >= 0 && held_excl[e] != '0 && held_excl[e] != slot) begin
          ans.status = selt_pkg::STAT_CONF_X;
          ans.holder = held_excl[e];
        end else if (e >= 0 && kind == selt_pkg::REQ_EXCL &&
                     (held_shared[e] & ~own) != '0) begin
          others = held_shared[e] & ~own;
          ans.status = selt_pkg::STAT_CONF_S;
          // Walk down so the lowest-numbered other holder wins.
          for (int i = 31; i >= 0; i--)
            if (others[i]) ans.holder = 5'(i);
        end else begin
          if (e < 0) begin
            e = first_free_entry();
            if (e >= 0) begin
              held_valid[e]  = 1'b1;
              held_key[e]    = key;
              held_excl[e]   = '0;
              held_shared[e] = '0;
            end
          end
          if (e < 0) begin
            ans.status = selt_pkg::STAT_FULL;
          end else if (kind == selt_pkg::REQ_SHARED) begin
            held_shared[e] = held_shared[e] | own;
          end else begin
            held_shared[e] = held_shared[e] & ~own;
            held_excl[e]   = slot;
          end
        end
      end
      selt_pkg::REQ_UNLOCK: begin
        e = lookup_key(key);
        if (e >= 0) drop_slot_holds(e, slot);
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++)
          if (held_valid[i]) drop_slot_holds(i, slot);
      end
    endcase
    return ans;
  endfunction

  // Called right after a rising edge; returns at the edge where the request is taken.
  task automatic send_request(selt_pkg::req_t kind, logic [4:0] slot, logic [31:0] key);
    while (!steady && $urandom_range(99) < 17) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.req_type     <= kind;
    in_req.tx_slot      <= slot;
    in_req.resource_key <= key;
    do @(posedge clk); while (!in_req.ready);
    pending_answers.push_back(predict_lock_answer(kind, slot, key));
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  // Response side: random stalls, plus a long hold-off when the test asks for one.
  always @(posedge clk) begin : drive_rsp_ready
    int stall_left;
    bit hold_seen;
    if (hold_req != hold_seen) begin
      hold_seen  = hold_req;
      stall_left = hold_cycles;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= steady || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin : check_answers
    lock_answer_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = pending_answers.pop_front();
        if (out_rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", out_rsp.status, want.status));
        if (out_rsp.holder_tx !== want.holder)
          report_mismatch($sformatf("holder_tx %0d, wanted %0d",
                                    out_rsp.holder_tx, want.holder));
      end
    end
  end

  task automatic test_lock_rules();
    send_request(selt_pkg::REQ_SHARED, 5'd0, KEY_A);    // no slot: ignored
    send_request(selt_pkg::REQ_SHARED, 5'd3, KEY_A);
    send_request(selt_pkg::REQ_SHARED, 5'd5, KEY_A);
    send_request(selt_pkg::REQ_EXCL, 5'd9, KEY_A);      // other shared holders
    send_request(selt_pkg::REQ_EXCL, 5'd3, KEY_A);      // own bit is not a conflict
    send_request(selt_pkg::REQ_UNLOCK, 5'd5, KEY_A);
    send_request(selt_pkg::REQ_EXCL, 5'd3, KEY_A);      // upgrade
    send_request(selt_pkg::REQ_SHARED, 5'd3, KEY_A);    // shared on top of own exclusive
    send_request(selt_pkg::REQ_EXCL, 5'd3, KEY_A);      // already held
    send_request(selt_pkg::REQ_SHARED, 5'd7, KEY_A);
    send_request(selt_pkg::REQ_EXCL, 5'd31, KEY_A);
    send_request(selt_pkg::REQ_SHARED, 5'd1, 32'h0000_0000);
    send_request(selt_pkg::REQ_SHARED, 5'd31, 32'hFFFF_FFFF);
    send_request(selt_pkg::REQ_UNLOCK, 5'd2, 32'h1234_5678);
    send_request(selt_pkg::REQ_UNLOCK, 5'd9, KEY_A);
    send_request(selt_pkg::REQ_EXCL, 5'd31, 32'hFFFF_FFFF);
    send_request(selt_pkg::REQ_EXCL, 5'd1, 32'hFFFF_FFFF);
    send_request(selt_pkg::REQ_SHARED, 5'd4, KEY_B);
    send_request(selt_pkg::REQ_SHARED, 5'd6, KEY_B);
    send_request(selt_pkg::REQ_SHARED, 5'd2, KEY_B);
    send_request(selt_pkg::REQ_EXCL, 5'd6, KEY_B);      // lowest other holder reported
    send_request(selt_pkg::REQ_EXCL, 5'd0, KEY_B);
    send_request(selt_pkg::REQ_RELEASE, 5'd0, $urandom);
    send_request(selt_pkg::REQ_RELEASE, 5'd3, $urandom);
    send_request(selt_pkg::REQ_RELEASE, 5'd31, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_table_full();
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < ENTRIES; i++)
      send_request($urandom_range(1) ? selt_pkg::REQ_EXCL : selt_pkg::REQ_SHARED,
                   5'(1 + i % 31), base + i);
    send_request(selt_pkg::REQ_EXCL, 5'd5, base + 200);
    send_request(selt_pkg::REQ_SHARED, 5'd0, base + 201);
    send_request(selt_pkg::REQ_SHARED, 5'd20, base + 3);
    send_request(selt_pkg::REQ_UNLOCK, 5'd8, base + 7);
    send_request(selt_pkg::REQ_SHARED, 5'd11, base + 300);
    send_request(selt_pkg::REQ_SHARED, 5'd12, base + 301);
    for (int s = 1; s < 32; s++) send_request(selt_pkg::REQ_RELEASE, 5'(s), $urandom);
    wait_drained();
  endtask

  task automatic test_response_hold();
    hold_cycles = 600;
    hold_req    = !hold_req;
    for (int i = 0; i < 10; i++)
      send_request($urandom_range(1) ? selt_pkg::REQ_EXCL : selt_pkg::REQ_SHARED,
                   5'($urandom_range(1, 31)), $urandom_range(1) ? KEY_A : KEY_B);
    send_request(selt_pkg::REQ_RELEASE, 5'($urandom_range(1, 31)), $urandom);
    wait_drained();
  endtask

  task automatic test_random_traffic(int n_items, int n_keys, int n_slots);
    logic [31:0]    keys[$];
    logic [4:0]     slots[$];
    logic [4:0]     slot;
    int             pick;
    selt_pkg::req_t kind;
    for (int i = 0; i < n_keys; i++) keys.push_back($urandom);
    for (int i = 0; i < n_slots; i++) slots.push_back(5'($urandom_range(1, 31)));
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      kind = pick < 36 ? selt_pkg::REQ_SHARED : pick < 68 ? selt_pkg::REQ_EXCL :
             pick < 93 ? selt_pkg::REQ_UNLOCK : selt_pkg::REQ_RELEASE;
      slot = ($urandom_range(49) == 0) ? 5'd0 : slots[$urandom_range(n_slots - 1)];
      if (kind == selt_pkg::REQ_RELEASE || $urandom_range(49) == 0)
        send_request(kind, slot, $urandom);
      else
        send_request(kind, slot, keys[$urandom_range(n_keys - 1)]);
    end
    wait_drained();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_req.valid        = 1'b0;
    in_req.req_type     = selt_pkg::REQ_SHARED;
    in_req.tx_slot      = '0;
    in_req.resource_key = '0;
    out_rsp.ready       = 1'b0;
    foreach (held_valid[i]) held_valid[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_lock_rules();
    test_table_full();
    test_response_hold();
    test_random_traffic(300, 4, 4);
    steady = 1'b1;
    test_random_traffic(300, 24, 12);
    steady = 1'b0;
    test_random_traffic(400, 90, 31);
    test_random_traffic(170, 12, 31);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("shared_exclusive_lock_table_tb OK");
    end else begin
      $display("shared_exclusive_lock_table_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/selt_pkg.sv
hw/rtl/selt_if.sv
hw/rtl/shared_exclusive_lock_table.sv
bench/shared_exclusive_lock_table_tb.sv
